// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the frame gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IFG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define IFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/ifg_pkg.sv -----
`timescale 1ns / 1ps
package ifg_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_ONE      = 8'h01;
	localparam logic [1:0] ZERO_RUN_MAX  = 2'd2;

	localparam logic REG_SKIP_COUNT = 1'b0;
	localparam logic REG_IDR_ONLY   = 1'b1;

	typedef enum logic [2:0] {
		V_PASSED  = 3'd0,
		V_AWAIT   = 3'd1,
		V_NOT_IDR = 3'd2,
		V_SKIPPED = 3'd3,
		V_OTHER   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic idr;
		logic other_stream;
	} frame_info_t;

	typedef struct packed {
		logic        valid;
		frame_info_t info;
	} frame_push_t;

	typedef struct packed {
		logic [7:0] skip_count;
		logic       idr_only;
	} cfg_t;

endpackage

// ----- hw/rtl/ifg_if.sv -----
`timescale 1ns / 1ps
interface ifg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;
	logic [3:0] stream_id;

	modport source (output valid, data_byte, frame_last, stream_id, input ready);
	modport sink (input valid, data_byte, frame_last, stream_id, output ready);
endinterface

interface ifg_out_if;
	logic       valid;
	logic       ready;
	logic       forward;
	logic       frame_is_idr;
	logic [2:0] verdict;

	modport source (output valid, forward, frame_is_idr, verdict, input ready);
	modport sink (input valid, forward, frame_is_idr, verdict, output ready);
endinterface

// ----- hw/rtl/ifg_front.sv -----
`timescale 1ns / 1ps
module ifg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ifg_in_if.sink               in_ch,
	input  logic                 q_full,
	output ifg_pkg::frame_push_t push
);
	import ifg_pkg::*;

	logic [1:0] zero_run_q;
	logic       header_next_q;
	logic       idr_found_q;
	logic       accept;
	logic       hit;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign hit         = header_next_q && !in_ch.frame_last
		&& ((in_ch.data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR);

	// header byte on the last byte never counts, so idr_found_q is final there
	assign push.valid             = accept && in_ch.frame_last;
	assign push.info.idr          = idr_found_q;
	assign push.info.other_stream = (in_ch.stream_id != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q    <= 2'd0;
			header_next_q <= 1'b0;
			idr_found_q   <= 1'b0;
		end else if (accept) begin
			if (in_ch.frame_last) begin
				zero_run_q    <= 2'd0;
				header_next_q <= 1'b0;
				idr_found_q   <= 1'b0;
			end else begin
				idr_found_q   <= idr_found_q | hit;
				header_next_q <= (zero_run_q >= ZERO_RUN_MAX) && (in_ch.data_byte == BYTE_ONE);
				if (in_ch.data_byte == BYTE_ZERO) begin
					zero_run_q <= (zero_run_q >= ZERO_RUN_MAX) ? ZERO_RUN_MAX
						: zero_run_q + 2'd1;
				end else begin
					zero_run_q <= 2'd0;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/ifg_fifo.sv -----
`timescale 1ns / 1ps
module ifg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifg_pkg::frame_push_t push,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output ifg_pkg::frame_info_t head
);
	import ifg_pkg::*;

	frame_info_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/ifg_back.sv -----
`timescale 1ns / 1ps
module ifg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifg_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	input  ifg_pkg::frame_info_t q_head,
	output logic                 q_pop,
	ifg_out_if.source            out_ch,
	output logic                 awaiting
);
	import ifg_pkg::*;

	logic       awaiting_q;
	logic [7:0] phase_q;
	logic       out_valid_q;
	logic       forward_q;
	logic       idr_q;
	verdict_t   verdict_q;

	verdict_t   verdict_d;
	logic       awaiting_d;
	logic [7:0] phase_d;

	assign q_pop        = q_valid && (!out_valid_q || out_ch.ready);
	assign awaiting     = awaiting_q;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.forward      = forward_q;
	assign out_ch.frame_is_idr = idr_q;
	assign out_ch.verdict      = verdict_q;

	always_comb begin
		verdict_d  = V_PASSED;
		awaiting_d = awaiting_q;
		phase_d    = phase_q;
		if (q_head.other_stream) begin
			verdict_d = V_OTHER;
		end else if (awaiting_q && !q_head.idr) begin
			verdict_d = V_AWAIT;
		end else begin
			awaiting_d = 1'b0;
			if (cfg.idr_only && !q_head.idr) begin
				verdict_d = V_NOT_IDR;
			end else if (cfg.skip_count != 8'd0 && !cfg.idr_only) begin
				phase_d   = (phase_q >= cfg.skip_count) ? 8'd0 : phase_q + 8'd1;
				verdict_d = (phase_q == 8'd0) ? V_PASSED : V_SKIPPED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			phase_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				awaiting_q  <= awaiting_d;
				phase_q     <= phase_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			verdict_q <= verdict_d;
			forward_q <= (verdict_d == V_PASSED);
			idr_q     <= q_head.idr;
		end
	end

endmodule

// ----- hw/rtl/h264_idr_frame_gate.sv -----
// A frame's verdict passes through the verdict queue and then the output register.
// Throughput: one byte per cycle; the two-entry verdict queue and the output
// register hold up to three pending verdicts while the result side stalls,
// after which the input is held off until a word leaves.
// Reset (arst_n low, asynchronous): scanner and queue cleared, waiting for
// the first IDR frame, skip phase 0, skip_count 0, idr_only 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module h264_idr_frame_gate (
	input  logic        clk,
	input  logic        arst_n,
	ifg_in_if.sink      in_ch,
	ifg_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ifg_pkg::*;

	logic [7:0]  skip_count_q;
	logic        idr_only_q;
	cfg_t        cfg;
	frame_push_t push;
	frame_info_t q_head;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	logic        awaiting;

	assign pready         = 1'b1;
	assign cfg.skip_count = skip_count_q;
	assign cfg.idr_only   = idr_only_q;

	always_comb begin
		unique case (paddr[2])
			REG_SKIP_COUNT: prdata = {24'd0, skip_count_q};
			REG_IDR_ONLY:   prdata = {31'd0, idr_only_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q <= 8'd0;
			idr_only_q   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_SKIP_COUNT: skip_count_q <= pwdata[7:0];
				REG_IDR_ONLY:   idr_only_q   <= pwdata[0];
				default:        skip_count_q <= skip_count_q;
			endcase
		end
	end

	ifg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push)
	);

	ifg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	ifg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_ch   (out_ch),
		.awaiting (awaiting)
	);

	`IFG_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_full, !push.valid)
	`IFG_ASSERT_NEXT(a_idr_wait_once, clk, arst_n, !awaiting, !awaiting)
	`IFG_ASSERT_IMPLY(a_forward_pass, clk, arst_n, out_ch.valid, out_ch.forward == (out_ch.verdict == V_PASSED))
endmodule
